/* rtl/core/lzsd_pkg.sv */
// ----------------------------------------------------------------------------
// lzsd_pkg: shared constants and types of the LZSS ring decoder
// Ring geometry, match limits, length cap, the sequencer state type and the result struct.
// ----------------------------------------------------------------------------
package lzsd_pkg;

  localparam int RING_DEPTH = 4096;
  localparam int RING_AW    = $clog2(RING_DEPTH);
  localparam int FILL_W     = RING_AW + 1;
  localparam int MAX_MATCH  = 18;
  localparam int MIN_MATCH  = 3;
  localparam int MCNT_W     = $clog2(MAX_MATCH + 1);
  localparam int LEN_W      = 29;
  localparam int BYTE_W     = 8;
  localparam int FLAG_W     = BYTE_W + 1;

  // largest accepted output length
  localparam logic [LEN_W-1:0]   LENGTH_CAP = LEN_W'(268435456);
  // first ring slot written after reset
  localparam logic [RING_AW-1:0] WP_RESET   = RING_AW'(RING_DEPTH - MAX_MATCH);

  typedef enum logic [1:0] {
    S_IDLE,  // waiting for a packed byte
    S_HOLD,  // single result parked until the output register frees
    S_MRD,   // first ring read of a match
    S_MCP    // copy loop: one ring byte per free output slot
  } state_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              run_last;
    logic              stream_end;
    logic              truncated;
  } result_t;

endpackage

/* rtl/core/lzsd_ram.sv */
// ----------------------------------------------------------------------------
// lzsd_ram: generic single-port-write, single-port-read synchronous RAM
// One write and one registered read per cycle; read returns old data on
// a same-address write.
// ----------------------------------------------------------------------------
module lzsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/lzss_ring_decoder.sv */
// ----------------------------------------------------------------------------
// lzss_ring_decoder: byte-serial flag-byte LZSS decoder, 4096-byte ring
// Packed bytes enter one transaction at a time on the in_ channel; decoded
// bytes leave one transaction each on the out_ channel. Flag bits are used
// LSB first: a set bit passes a literal, a clear bit takes two bytes giving
// a 12-bit ring position and a 4-bit length (+3). The ring lives in one
// synchronous RAM; it reads as zero where never written, tracked by a fill
// count, so there is no clearing pass after reset. A match second byte
// starts a first ring read, then the copy loop, which reads one ring byte
// per cycle through the single read port while the output is not stalled;
// a stalled output stretches the copy loop. The input is stalled until
// the copy ends. Decoding stops after cfg_wr_data bytes; a final byte that
// leaves output short yields one error transaction (out_byte 0, truncated
// set). Write the length only while idle.
// ----------------------------------------------------------------------------
module lzss_ring_decoder (
  input  logic                         clk,
  input  logic                         rst_n,
  // configuration
  input  logic                         cfg_wr_en,
  input  logic [lzsd_pkg::LEN_W-1:0]   cfg_wr_data,
  // packed input
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [lzsd_pkg::BYTE_W-1:0]  in_packed_byte,
  input  logic                         in_final_packed,
  // decoded output
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [lzsd_pkg::BYTE_W-1:0]  out_byte,
  output logic                         out_run_last,
  output logic                         out_stream_end,
  output logic                         out_truncated
);

  localparam int AW = lzsd_pkg::RING_AW;
  localparam int LW = lzsd_pkg::LEN_W;
  localparam int BW = lzsd_pkg::BYTE_W;
  localparam int MW = lzsd_pkg::MCNT_W;

  // control state
  lzsd_pkg::state_t state_r, state_nxt;
  logic [lzsd_pkg::FLAG_W-1:0] flag_r, flag_nxt;     // flag bits under marker
  logic                        pend_r, pend_nxt;     // match first byte held
  logic [BW-1:0]               pfirst_r, pfirst_nxt; // match first byte
  logic [LW-1:0]               count_r, count_nxt;   // bytes produced
  logic                        done_r, done_nxt;     // stream finished
  logic [LW-1:0]               olen_r, olen_nxt;     // configured length
  logic [AW-1:0]               wp_r, wp_nxt;         // ring write pointer
  logic [lzsd_pkg::FILL_W-1:0] fill_r, fill_nxt;     // ring slots written
  logic [AW-1:0]               src_r, src_nxt;       // match read pointer
  logic [MW-1:0]               mcnt_r, mcnt_nxt;     // match bytes left

  // read-side bookkeeping for the RAM result
  logic          rfwd_r, rfwd_nxt;    // read hit the concurrent write
  logic [BW-1:0] rfdat_r, rfdat_nxt;  // forwarded write data
  logic          rvld_r, rvld_nxt;    // read slot was written before

  // output register and parked single result
  logic                 out_valid_r, out_valid_nxt;
  lzsd_pkg::result_t    out_r, out_nxt;
  lzsd_pkg::result_t    hold_r, hold_nxt;

  // RAM port
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [BW-1:0] ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [BW-1:0] ram_rdata;

  // datapath helpers
  logic                 accept;
  logic                 slot_free;
  logic [BW-1:0]        rd_byte;
  logic [LW-1:0]        remaining;
  logic [LW-1:0]        cnt_inc;
  logic                 reach_end;
  logic [MW-1:0]        mlen;
  logic                 single_vld;
  lzsd_pkg::result_t    single_res;
  logic [AW-1:0]        rd_offset;

  lzsd_ram #(
    .WIDTH (BW),
    .DEPTH (lzsd_pkg::RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_stall  = (state_r != lzsd_pkg::S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;

  // ring byte: forwarded write, stored data, or zero for an unwritten slot
  assign rd_byte   = rfwd_r ? rfdat_r : (rvld_r ? ram_rdata : '0);

  assign remaining = olen_r - count_r;
  assign cnt_inc   = count_r + LW'(1);
  assign reach_end = (cnt_inc >= olen_r);
  assign mlen      = MW'(in_packed_byte[3:0]) + MW'(lzsd_pkg::MIN_MATCH);

  assign out_valid      = out_valid_r;
  assign out_byte       = out_r.data;
  assign out_run_last   = out_r.run_last;
  assign out_stream_end = out_r.stream_end;
  assign out_truncated  = out_r.truncated;

  always_comb begin
    state_nxt     = state_r;
    flag_nxt      = flag_r;
    pend_nxt      = pend_r;
    pfirst_nxt    = pfirst_r;
    count_nxt     = count_r;
    done_nxt      = done_r;
    olen_nxt      = cfg_wr_en ? cfg_wr_data : olen_r;
    wp_nxt        = wp_r;
    fill_nxt      = fill_r;
    src_nxt       = src_r;
    mcnt_nxt      = mcnt_r;
    rfwd_nxt      = rfwd_r;
    rfdat_nxt     = rfdat_r;
    rvld_nxt      = rvld_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    hold_nxt      = hold_r;
    ram_we        = 1'b0;
    ram_waddr     = wp_r;
    ram_wdata     = in_packed_byte;
    ram_re        = 1'b0;
    ram_raddr     = src_r;
    single_vld    = 1'b0;
    single_res    = '{data: '0, run_last: 1'b1, stream_end: 1'b1, truncated: 1'b1};
    rd_offset     = '0;

    case (state_r)
      lzsd_pkg::S_IDLE: begin
        if (accept && !done_r) begin
          if (olen_r > lzsd_pkg::LENGTH_CAP) begin
            // length out of range: error transaction
            done_nxt   = 1'b1;
            single_vld = 1'b1;
          end else if (count_r >= olen_r) begin
            // length reached (or zero): stop quietly
            done_nxt = 1'b1;
          end else if (pend_r) begin
            pend_nxt = 1'b0;
            flag_nxt = flag_r >> 1;
            if (in_final_packed && (remaining > LW'(mlen))) begin
              done_nxt   = 1'b1;
              single_vld = 1'b1;
            end else begin
              src_nxt   = {in_packed_byte[7:4], pfirst_r};
              mcnt_nxt  = (remaining < LW'(mlen)) ? remaining[MW-1:0] : mlen;
              state_nxt = lzsd_pkg::S_MRD;
            end
          end else if (flag_r[lzsd_pkg::FLAG_W-1:1] == '0) begin
            // new flag byte under a marker bit
            flag_nxt = {1'b1, in_packed_byte};
            if (in_final_packed) begin
              done_nxt   = 1'b1;
              single_vld = 1'b1;
            end
          end else if (flag_r[0]) begin
            // literal
            flag_nxt  = flag_r >> 1;
            ram_we    = 1'b1;
            wp_nxt    = wp_r + AW'(1);
            fill_nxt  = fill_r[AW] ? fill_r : fill_r + lzsd_pkg::FILL_W'(1);
            count_nxt = cnt_inc;
            done_nxt  = reach_end || in_final_packed;
            single_vld = 1'b1;
            if (!(in_final_packed && !reach_end)) begin
              single_res = '{data: in_packed_byte, run_last: 1'b1,
                             stream_end: reach_end, truncated: 1'b0};
            end
          end else begin
            // first byte of a match
            pfirst_nxt = in_packed_byte;
            pend_nxt   = 1'b1;
            if (in_final_packed) begin
              done_nxt   = 1'b1;
              single_vld = 1'b1;
            end
          end
        end
      end

      lzsd_pkg::S_HOLD: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_nxt       = hold_r;
          state_nxt     = lzsd_pkg::S_IDLE;
        end
      end

      lzsd_pkg::S_MRD: begin
        ram_re    = 1'b1;
        src_nxt   = src_r + AW'(1);
        state_nxt = lzsd_pkg::S_MCP;
      end

      lzsd_pkg::S_MCP: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '{data: rd_byte, run_last: (mcnt_r == MW'(1)),
                            stream_end: reach_end, truncated: 1'b0};
          ram_we        = 1'b1;
          ram_wdata     = rd_byte;
          wp_nxt        = wp_r + AW'(1);
          fill_nxt      = fill_r[AW] ? fill_r : fill_r + lzsd_pkg::FILL_W'(1);
          count_nxt     = cnt_inc;
          done_nxt      = done_r || reach_end;
          mcnt_nxt      = mcnt_r - MW'(1);
          if (mcnt_r == MW'(1)) begin
            state_nxt = lzsd_pkg::S_IDLE;
          end else begin
            // next read overlaps this write when the match trails the pointer
            ram_re  = 1'b1;
            src_nxt = src_r + AW'(1);
          end
        end
      end

      default: begin
        state_nxt = lzsd_pkg::S_IDLE;
      end
    endcase

    // single result: straight to the output register, else park it
    if (single_vld) begin
      if (slot_free) begin
        out_valid_nxt = 1'b1;
        out_nxt       = single_res;
      end else begin
        hold_nxt  = single_res;
        state_nxt = lzsd_pkg::S_HOLD;
      end
    end

    // read tracking: forward a same-slot write, zero a never-written slot
    if (ram_re) begin
      rd_offset = ram_raddr - lzsd_pkg::WP_RESET;
      rfwd_nxt  = ram_we && (ram_waddr == ram_raddr);
      rfdat_nxt = ram_wdata;
      rvld_nxt  = ({1'b0, rd_offset} < fill_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lzsd_pkg::S_IDLE;
      flag_r      <= '0;
      pend_r      <= 1'b0;
      pfirst_r    <= '0;
      count_r     <= '0;
      done_r      <= 1'b0;
      olen_r      <= '0;
      wp_r        <= lzsd_pkg::WP_RESET;
      fill_r      <= '0;
      mcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      flag_r      <= flag_nxt;
      pend_r      <= pend_nxt;
      pfirst_r    <= pfirst_nxt;
      count_r     <= count_nxt;
      done_r      <= done_nxt;
      olen_r      <= olen_nxt;
      wp_r        <= wp_nxt;
      fill_r      <= fill_nxt;
      mcnt_r      <= mcnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    src_r   <= src_nxt;
    rfwd_r  <= rfwd_nxt;
    rfdat_r <= rfdat_nxt;
    rvld_r  <= rvld_nxt;
    out_r   <= out_nxt;
    hold_r  <= hold_nxt;
  end

endmodule

/* rtl/core/lzsd_checker.sv */
// ----------------------------------------------------------------------------
// lzsd_checker: port-level checks for the LZSS ring decoder
// Output channel behavior and end-of-stream marking, bound to the top level.
// ----------------------------------------------------------------------------
module lzsd_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [lzsd_pkg::BYTE_W-1:0]  out_byte,
  input logic                         out_run_last,
  input logic                         out_stream_end,
  input logic                         out_truncated
);

  // stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("out_valid dropped while stalled");

  // stalled payload stays put
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_byte) && $stable(out_run_last)
      && $stable(out_stream_end) && $stable(out_truncated))
    else $error("out payload changed while stalled");

  // error transaction is a lone, terminal, zero byte
  a_trunc_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_truncated |-> out_stream_end && out_run_last
      && (out_byte == '0))
    else $error("malformed error transaction");

  // end of stream closes the current run
  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stream_end |-> out_run_last)
    else $error("stream end not on last result of its input");

  // nothing follows the end of stream
  a_end_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_stream_end |=> !out_valid)
    else $error("result after end of stream");

endmodule

bind lzss_ring_decoder lzsd_checker u_lzsd_checker (.*);
